// ----- design/gpvu_pkg.sv -----
// Shared constants and register codes for the gradient projection vector update.
package gpvu_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Weight is Q1.15, learning rate Q4.12.
  localparam int unsigned W_FRAC  = 15;
  localparam int unsigned LR_FRAC = 12;
  localparam logic [17:0] ONE_Q15 = 18'd32768;

  // Projected vector u saturates to +-(2^45 - 1).
  localparam int unsigned          U_BITS  = 46;
  localparam logic signed [45:0]   U_LIMIT = 46'sh1FFF_FFFF_FFFF;

  localparam logic [15:0] LEARN_RATE_RST     = 16'd4096;
  localparam logic [15:0] BLEND_WEIGHT_RST   = 16'd16384;
  localparam logic [22:0] CLAMP_LIMIT_RST    = 23'd4177920;
  localparam logic [13:0] ZERO_THRESHOLD_RST = 14'd0;

  typedef enum logic [1:0] {
    REG_LEARN_RATE     = 2'd0,
    REG_BLEND_WEIGHT   = 2'd1,
    REG_CLAMP_LIMIT    = 2'd2,
    REG_ZERO_THRESHOLD = 2'd3
  } reg_idx_e;

endpackage

// ----- design/gpvu_div_cell.sv -----
// One restoring-division cell: retires one quotient bit for both lanes per cycle while en_i is high.
module gpvu_div_cell #(
  parameter int unsigned MW  = 63,
  parameter int unsigned NW  = 34,
  parameter int unsigned SDW = 51
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [SDW-1:0]  side_i,
  input  logic [NW-1:0]   n_i,
  input  logic [MW-1:0]   div_x_i,
  input  logic [MW-1:0]   div_y_i,
  input  logic [NW:0]     rem_x_i,
  input  logic [NW:0]     rem_y_i,
  input  logic [MW-1:0]   quot_x_i,
  input  logic [MW-1:0]   quot_y_i,
  output logic            valid_o,
  output logic [SDW-1:0]  side_o,
  output logic [NW-1:0]   n_o,
  output logic [MW-1:0]   div_x_o,
  output logic [MW-1:0]   div_y_o,
  output logic [NW:0]     rem_x_o,
  output logic [NW:0]     rem_y_o,
  output logic [MW-1:0]   quot_x_o,
  output logic [MW-1:0]   quot_y_o
);

  logic [NW:0]  sh_x, sh_y, rem_x_d, rem_y_d;
  logic         ge_x, ge_y;
  logic         valid_q;
  logic [SDW-1:0] side_q;
  logic [NW-1:0]  n_q;
  logic [MW-1:0]  div_x_q, div_y_q, quot_x_q, quot_y_q;
  logic [NW:0]    rem_x_q, rem_y_q;

  // Bring down the next dividend bit, subtract when the divisor fits.
  always_comb begin
    sh_x    = {rem_x_i[NW-1:0], div_x_i[MW-1]};
    sh_y    = {rem_y_i[NW-1:0], div_y_i[MW-1]};
    ge_x    = (sh_x >= {1'b0, n_i});
    ge_y    = (sh_y >= {1'b0, n_i});
    rem_x_d = ge_x ? (sh_x - {1'b0, n_i}) : sh_x;
    rem_y_d = ge_y ? (sh_y - {1'b0, n_i}) : sh_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q   <= side_i;
      n_q      <= n_i;
      div_x_q  <= {div_x_i[MW-2:0], 1'b0};
      div_y_q  <= {div_y_i[MW-2:0], 1'b0};
      rem_x_q  <= rem_x_d;
      rem_y_q  <= rem_y_d;
      quot_x_q <= {quot_x_i[MW-2:0], ge_x};
      quot_y_q <= {quot_y_i[MW-2:0], ge_y};
    end
  end

  assign valid_o  = valid_q;
  assign side_o   = side_q;
  assign n_o      = n_q;
  assign div_x_o  = div_x_q;
  assign div_y_o  = div_y_q;
  assign rem_x_o  = rem_x_q;
  assign rem_y_o  = rem_y_q;
  assign quot_x_o = quot_x_q;
  assign quot_y_o = quot_y_q;

endmodule

// ----- design/gradient_projection_vector_update.sv -----
// Gradient projection vector update: fully pipelined, one item per cycle unless stalled.
//
// Accepts one item per clock while in_stall_o is low and returns one result per item, in
// order. At the default widths it has three front stages (products, dot product and
// norm, B*(V+d)), one cell per quotient bit of the 63-bit magnitude of B*(V+d)
// divided by |B|^2, then four stages for u = A - q with saturation, the blend, the
// learning-rate scaling and the clamp into the output register. The divider cell
// row is the longest part of the pipeline. A stall on the output holds the whole pipeline.
// Configuration registers are read by the pipeline directly; write them only while
// no item is in flight.
module gradient_projection_vector_update #(
  parameter int unsigned DATA_WIDTH = 24,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gpvu_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [gpvu_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [gpvu_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [DATA_WIDTH-1:0]         vec_a_x_i,
  input  logic signed [DATA_WIDTH-1:0]         vec_a_y_i,
  input  logic signed [DATA_WIDTH-1:0]         vec_b_x_i,
  input  logic signed [DATA_WIDTH-1:0]         vec_b_y_i,
  input  logic signed [DATA_WIDTH-1:0]         temporal_term_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [DATA_WIDTH-1:0]         new_x_o,
  output logic signed [DATA_WIDTH-1:0]         new_y_o,
  output logic                                 zero_norm_o
);
  import gpvu_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned NW   = 2 * DW - F;
  localparam int unsigned DTW  = 2 * DW - F + 1;
  localparam int unsigned EW0  = ((DTW > DW) ? DTW : DW) + 1;
  localparam int unsigned SW   = 64 - DW;
  localparam int unsigned EW   = (EW0 > SW) ? EW0 : SW;
  localparam int unsigned BSW  = DW + SW;
  localparam int unsigned MW   = BSW - 1;
  localparam int unsigned QW   = MW + 1;
  localparam int unsigned DFW  = QW + 1;
  localparam int unsigned UW   = U_BITS;
  localparam int unsigned T1W  = 18 + DW;
  localparam int unsigned WUW  = 17 + UW;
  localparam int unsigned LPW  = 17 + WUW;
  localparam int unsigned RSW  = LPW + 1;
  localparam int unsigned SDW  = 3 + 2 * DW;
  localparam logic signed [EW-1:0]  SLIM = EW'((65'sd1 <<< (63 - DW)) - 65'sd1);
  localparam logic signed [RSW-1:0] OMAX = RSW'((65'sd1 <<< (DW - 1)) - 65'sd1);

  // ---------------- configuration registers ----------------
  logic [15:0] learn_rate_q, blend_weight_q;
  logic [22:0] clamp_limit_q;
  logic [13:0] zero_threshold_q;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q     <= LEARN_RATE_RST;
      blend_weight_q   <= BLEND_WEIGHT_RST;
      clamp_limit_q    <= CLAMP_LIMIT_RST;
      zero_threshold_q <= ZERO_THRESHOLD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_LEARN_RATE:     learn_rate_q     <= pwdata[15:0];
        REG_BLEND_WEIGHT:   blend_weight_q   <= pwdata[15:0];
        REG_CLAMP_LIMIT:    clamp_limit_q    <= pwdata[22:0];
        REG_ZERO_THRESHOLD: zero_threshold_q <= pwdata[13:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LEARN_RATE:     prdata = {16'd0, learn_rate_q};
      REG_BLEND_WEIGHT:   prdata = {16'd0, blend_weight_q};
      REG_CLAMP_LIMIT:    prdata = {9'd0, clamp_limit_q};
      REG_ZERO_THRESHOLD: prdata = {18'd0, zero_threshold_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic out_valid_q;
  logic en;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- stage 1: products ----------------
  logic                 v1_q;
  logic signed [PW-1:0] pab_x_q, pab_y_q, pbb_x_q, pbb_y_q;
  logic signed [DW-1:0] a1x_q, a1y_q, b1x_q, b1y_q, vt1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pab_x_q <= vec_a_x_i * vec_b_x_i;
      pab_y_q <= vec_a_y_i * vec_b_y_i;
      pbb_x_q <= vec_b_x_i * vec_b_x_i;
      pbb_y_q <= vec_b_y_i * vec_b_y_i;
      a1x_q   <= vec_a_x_i;
      a1y_q   <= vec_a_y_i;
      b1x_q   <= vec_b_x_i;
      b1y_q   <= vec_b_y_i;
      vt1_q   <= temporal_term_i;
    end
  end

  // ---------------- stage 2: dot product, norm, V + d ----------------
  logic signed [PW-1:0]  tab_x, tab_y, tbb_x, tbb_y;
  logic signed [DTW-1:0] dot;
  logic [NW-1:0]         nrm;
  logic signed [EW-1:0]  sum, sum_sat;

  // Truncate toward zero: bias negative values before the arithmetic shift.
  assign tab_x = (pab_x_q + $signed({{(PW-F){1'b0}}, {F{pab_x_q[PW-1]}}})) >>> F;
  assign tab_y = (pab_y_q + $signed({{(PW-F){1'b0}}, {F{pab_y_q[PW-1]}}})) >>> F;
  assign tbb_x = pbb_x_q >>> F;
  assign tbb_y = pbb_y_q >>> F;
  assign dot   = $signed(tab_x[DTW-1:0]) + $signed(tab_y[DTW-1:0]);
  assign nrm   = {1'b0, tbb_x[NW-2:0]} + {1'b0, tbb_y[NW-2:0]};
  assign sum   = EW'(vt1_q) + EW'(dot);
  assign sum_sat = (sum > SLIM) ? SLIM : ((sum < -SLIM) ? -SLIM : sum);

  logic                 v2_q, zero2_q;
  logic signed [SW-1:0] s2_q;
  logic [NW-1:0]        n2_q;
  logic signed [DW-1:0] a2x_q, a2y_q, b2x_q, b2y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q    <= sum_sat[SW-1:0];
      n2_q    <= nrm;
      zero2_q <= (nrm == '0);
      a2x_q   <= a1x_q;
      a2y_q   <= a1y_q;
      b2x_q   <= b1x_q;
      b2y_q   <= b1y_q;
    end
  end

  // ---------------- stage 3: B * (V + d), split into sign and magnitude ----------------
  logic signed [BSW-1:0] bs_x, bs_y, ab_x, ab_y;

  assign bs_x = b2x_q * s2_q;
  assign bs_y = b2y_q * s2_q;
  assign ab_x = bs_x[BSW-1] ? -bs_x : bs_x;
  assign ab_y = bs_y[BSW-1] ? -bs_y : bs_y;

  logic                 v3_q;
  logic [SDW-1:0]       side3_q;
  logic [NW-1:0]        n3_q;
  logic [MW-1:0]        mag3x_q, mag3y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q <= {zero2_q, bs_x[BSW-1], bs_y[BSW-1], a2x_q, a2y_q};
      n3_q    <= n2_q;
      mag3x_q <= ab_x[MW-1:0];
      mag3y_q <= ab_y[MW-1:0];
    end
  end

  // ---------------- divider cell row ----------------
  logic           cv   [0:MW];
  logic [SDW-1:0] cs   [0:MW];
  logic [NW-1:0]  cn   [0:MW];
  logic [MW-1:0]  cdx  [0:MW];
  logic [MW-1:0]  cdy  [0:MW];
  logic [NW:0]    crx  [0:MW];
  logic [NW:0]    cry  [0:MW];
  logic [MW-1:0]  cqx  [0:MW];
  logic [MW-1:0]  cqy  [0:MW];

  assign cv[0]  = v3_q;
  assign cs[0]  = side3_q;
  assign cn[0]  = n3_q;
  assign cdx[0] = mag3x_q;
  assign cdy[0] = mag3y_q;
  assign crx[0] = '0;
  assign cry[0] = '0;
  assign cqx[0] = '0;
  assign cqy[0] = '0;

  for (genvar k = 0; k < MW; k++) begin : g_cell
    gpvu_div_cell #(
      .MW  (MW),
      .NW  (NW),
      .SDW (SDW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (cv[k]),
      .side_i   (cs[k]),
      .n_i      (cn[k]),
      .div_x_i  (cdx[k]),
      .div_y_i  (cdy[k]),
      .rem_x_i  (crx[k]),
      .rem_y_i  (cry[k]),
      .quot_x_i (cqx[k]),
      .quot_y_i (cqy[k]),
      .valid_o  (cv[k+1]),
      .side_o   (cs[k+1]),
      .n_o      (cn[k+1]),
      .div_x_o  (cdx[k+1]),
      .div_y_o  (cdy[k+1]),
      .rem_x_o  (crx[k+1]),
      .rem_y_o  (cry[k+1]),
      .quot_x_o (cqx[k+1]),
      .quot_y_o (cqy[k+1])
    );
  end

  // ---------------- stage 4: u = A - q, saturated ----------------
  logic                  dzero, dneg_x, dneg_y;
  logic signed [DW-1:0]  dax, day;
  logic signed [QW-1:0]  q_x, q_y;
  logic signed [DFW-1:0] df_x, df_y, ulim;

  assign {dzero, dneg_x, dneg_y, dax, day} = cs[MW];
  assign ulim = DFW'(U_LIMIT);
  // Zero norm: drop the quotient so u equals A.
  assign q_x  = dzero ? '0 : (dneg_x ? -$signed({1'b0, cqx[MW]}) : $signed({1'b0, cqx[MW]}));
  assign q_y  = dzero ? '0 : (dneg_y ? -$signed({1'b0, cqy[MW]}) : $signed({1'b0, cqy[MW]}));
  assign df_x = DFW'(dax) - DFW'(q_x);
  assign df_y = DFW'(day) - DFW'(q_y);

  logic                 v4_q, zero4_q;
  logic signed [UW-1:0] u4x_q, u4y_q;
  logic signed [DW-1:0] a4x_q, a4y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= cv[MW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u4x_q   <= (df_x > ulim) ? U_LIMIT : ((df_x < -ulim) ? -U_LIMIT : df_x[UW-1:0]);
      u4y_q   <= (df_y > ulim) ? U_LIMIT : ((df_y < -ulim) ? -U_LIMIT : df_y[UW-1:0]);
      zero4_q <= dzero;
      a4x_q   <= dax;
      a4y_q   <= day;
    end
  end

  // ---------------- stage 5: (1-w)*A and w*u ----------------
  logic signed [17:0]    omw;
  logic signed [16:0]    wsg;
  logic signed [T1W-1:0] p1x, p1y, t1x, t1y;
  logic signed [WUW-1:0] pwx, pwy, wux, wuy;

  assign omw = $signed(ONE_Q15 - {2'b00, blend_weight_q});
  assign wsg = $signed({1'b0, blend_weight_q});
  assign p1x = omw * a4x_q;
  assign p1y = omw * a4y_q;
  assign pwx = wsg * u4x_q;
  assign pwy = wsg * u4y_q;
  assign t1x = (p1x + $signed({{(T1W-W_FRAC){1'b0}}, {W_FRAC{p1x[T1W-1]}}})) >>> W_FRAC;
  assign t1y = (p1y + $signed({{(T1W-W_FRAC){1'b0}}, {W_FRAC{p1y[T1W-1]}}})) >>> W_FRAC;
  assign wux = (pwx + $signed({{(WUW-W_FRAC){1'b0}}, {W_FRAC{pwx[WUW-1]}}})) >>> W_FRAC;
  assign wuy = (pwy + $signed({{(WUW-W_FRAC){1'b0}}, {W_FRAC{pwy[WUW-1]}}})) >>> W_FRAC;

  logic                  v5_q, zero5_q;
  logic signed [T1W-1:0] t1x_q, t1y_q;
  logic signed [WUW-1:0] wux_q, wuy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1x_q   <= t1x;
      t1y_q   <= t1y;
      wux_q   <= wux;
      wuy_q   <= wuy;
      zero5_q <= zero4_q;
    end
  end

  // ---------------- stage 6: lr scaling and sum ----------------
  logic signed [16:0]    lrs;
  logic signed [LPW-1:0] plx, ply, t2x, t2y;

  assign lrs = $signed({1'b0, learn_rate_q});
  assign plx = lrs * wux_q;
  assign ply = lrs * wuy_q;
  assign t2x = (plx + $signed({{(LPW-LR_FRAC){1'b0}}, {LR_FRAC{plx[LPW-1]}}})) >>> LR_FRAC;
  assign t2y = (ply + $signed({{(LPW-LR_FRAC){1'b0}}, {LR_FRAC{ply[LPW-1]}}})) >>> LR_FRAC;

  logic                  v6_q, zero6_q;
  logic signed [RSW-1:0] r6x_q, r6y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r6x_q   <= RSW'(t2x) + RSW'(t1x_q);
      r6y_q   <= RSW'(t2y) + RSW'(t1y_q);
      zero6_q <= zero5_q;
    end
  end

  // ---------------- stage 7: clamp, zero small values, output register ----------------
  logic signed [RSW-1:0] gam, eps, cgx, cgy, cox, coy, mgx, mgy;

  assign gam = $signed({{(RSW-23){1'b0}}, clamp_limit_q});
  assign eps = $signed({{(RSW-14){1'b0}}, zero_threshold_q});
  assign cgx = (r6x_q > gam) ? gam : ((r6x_q < -gam) ? -gam : r6x_q);
  assign cgy = (r6y_q > gam) ? gam : ((r6y_q < -gam) ? -gam : r6y_q);
  assign cox = (cgx > OMAX) ? OMAX : ((cgx < -OMAX - 1) ? (-OMAX - 1) : cgx);
  assign coy = (cgy > OMAX) ? OMAX : ((cgy < -OMAX - 1) ? (-OMAX - 1) : cgy);
  assign mgx = cox[RSW-1] ? -cox : cox;
  assign mgy = coy[RSW-1] ? -coy : coy;

  logic signed [DW-1:0] new_x_q, new_y_q;
  logic                 zero_norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      new_x_q     <= (mgx < eps) ? '0 : cox[DW-1:0];
      new_y_q     <= (mgy < eps) ? '0 : coy[DW-1:0];
      zero_norm_q <= zero6_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_x_o     = new_x_q;
  assign new_y_o     = new_y_q;
  assign zero_norm_o = zero_norm_q;

endmodule
